### hdl/tlg_pkg.sv
// Shared types and constants for the tile layout geometry unit.
// No dependencies; used by every other file of the block but tlg_div.
`timescale 1ns / 1ps

package tlg_pkg;

    localparam int MAX_TILES = 64;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_ORIGIN_X      = 3'd2,
        REG_ORIGIN_Y      = 3'd3,
        REG_SPLIT_MARGIN  = 3'd4,
        REG_LAYOUT_MODE   = 3'd5,
        REG_MASTER_COUNT  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LAYOUT_VERT  = 2'd0,
        LAYOUT_HORIZ = 2'd1,
        LAYOUT_GRID  = 2'd2,
        LAYOUT_FULL  = 2'd3
    } layout_mode_t;

    // which division the shared divider runs
    typedef enum logic [2:0] {
        OP_SPLIT,
        OP_NCOLS,
        OP_ICOLS,
        OP_HROWS,
        OP_WCOLS,
        OP_WREM
    } div_op_t;

    typedef enum logic [1:0] {
        KIND_BAD,
        KIND_FULL,
        KIND_SPLIT,
        KIND_GRID
    } tile_kind_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        div_op_t div_op;
        logic    mul;
        logic    finish;
    } tlg_cmd_t;

    typedef struct packed {
        tile_kind_t kind;
        logic       need_wrem;
        logic       div_busy;
        logic       div_done;
        logic       out_free;
    } tlg_stat_t;

    // ceil(sqrt(n)) for the grid column count
    function automatic logic [3:0] grid_cols(input logic [6:0] n);
        logic [3:0] c;
        c = 4'd1;
        for (int k = 1; k <= 8; k++) begin
            if (7'(k * k) < n && c == 4'(k)) begin
                c = 4'(k + 1);
            end
        end
        return c;
    endfunction

endpackage

### hdl/tlg_div.sv
// Restoring divider, one quotient bit per cycle, 13-bit dividend by 7-bit divisor.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module tlg_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [12:0] dividend,
    input  logic [6:0]  divisor,
    output logic [12:0] quot,
    output logic [6:0]  remd,
    output logic        busy,
    output logic        done
);
    logic [12:0] q_reg;
    logic [6:0]  r_reg;
    logic [6:0]  d_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [7:0]  r_sh;
    logic [7:0]  r_sub;
    logic        take;

    // one restoring step
    always_comb begin
        r_sh  = {r_reg, q_reg[12]};
        r_sub = r_sh - {1'b0, d_reg};
        take  = r_sh >= {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= dividend;
                r_reg    <= 7'd0;
                d_reg    <= divisor;
                cnt_reg  <= 4'd13;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                q_reg   <= {q_reg[11:0], take};
                r_reg   <= take ? r_sub[6:0] : r_sh[6:0];
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg;
    assign remd = r_reg;
    assign busy = busy_reg;
    assign done = done_reg;
endmodule

### hdl/tlg_dp.sv
// Datapath: configuration registers, operand registers, shared divider,
// product stage and output register. Depends on tlg_pkg and tlg_div.
`timescale 1ns / 1ps

module tlg_dp (
    input  logic             aclk,
    input  logic             aresetn,
    input  tlg_pkg::tlg_cmd_t cmd,
    output tlg_pkg::tlg_stat_t stat,
    input  logic [15:0]      s_tdata,
    input  logic             cfg_valid,
    input  logic [2:0]       cfg_index,
    input  logic [13:0]      cfg_data,
    output logic [63:0]      m_tdata,
    output logic             m_tuser,
    output logic             m_tvalid,
    input  logic             m_tready
);
    import tlg_pkg::*;

    logic [12:0] sw_reg, sh_reg, mg_reg;
    logic [13:0] ox_reg, oy_reg;
    logic [1:0]  mode_reg;
    logic [6:0]  mc_reg;

    logic [5:0]  i_reg;
    logic [6:0]  n_reg;
    logic [3:0]  cols_reg;
    logic [12:0] sq_reg, hq_reg, wq_reg;
    logic [2:0]  rem_reg, ir_reg;
    logic [4:0]  iq_reg;
    div_op_t     op_reg;

    logic [14:0] xr_reg, yr_reg, wr_reg, hr_reg;
    logic        bad_reg;

    logic [63:0] tdata_reg;
    logic        tuser_reg, tvalid_reg;

    logic [12:0] dvd;
    logic [6:0]  dvs;
    logic [12:0] quot;
    logic [6:0]  remd;
    logic        div_busy, div_done;

    logic [3:0]  rows;
    logic        master;
    logic [6:0]  last_row_start;
    logic [6:0]  n_minus_i;
    tile_kind_t  kind;
    logic [14:0] mg_ext, half_w, half_h;
    logic [5:0]  fac;
    logic [18:0] p_split;
    logic [14:0] xn, yn, wn, hn;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg   <= 13'd1920;
            sh_reg   <= 13'd1080;
            ox_reg   <= 14'd0;
            oy_reg   <= 14'd0;
            mg_reg   <= 13'd120;
            mode_reg <= LAYOUT_VERT;
            mc_reg   <= 7'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  sw_reg   <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: sh_reg   <= cfg_data[12:0];
                REG_ORIGIN_X:      ox_reg   <= cfg_data;
                REG_ORIGIN_Y:      oy_reg   <= cfg_data;
                REG_SPLIT_MARGIN:  mg_reg   <= cfg_data[12:0];
                REG_LAYOUT_MODE:   mode_reg <= cfg_data[1:0];
                REG_MASTER_COUNT:  mc_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // classify the request
    always_comb begin
        if ({3'd0, cols_reg - 4'd1} * {3'd0, cols_reg} >= n_reg) begin
            rows = cols_reg - 4'd1;
        end else begin
            rows = cols_reg;
        end
        master         = {1'b0, i_reg} < mc_reg;
        n_minus_i      = n_reg - {1'b0, i_reg};
        last_row_start = {3'd0, cols_reg} * {3'd0, rows - 4'd1};
        if (n_reg == 7'd0 || {1'b0, i_reg} >= n_reg || n_reg > 7'(MAX_TILES)) begin
            kind = KIND_BAD;
        end else if (n_reg == 7'd1 || mode_reg == LAYOUT_FULL) begin
            kind = KIND_FULL;
        end else if (mode_reg == LAYOUT_GRID) begin
            kind = KIND_GRID;
        end else begin
            kind = KIND_SPLIT;
        end
    end

    // divider operand selection
    always_comb begin
        case (cmd.div_op)
            OP_SPLIT: begin
                dvd = (mode_reg == LAYOUT_VERT) ? sh_reg : sw_reg;
                dvs = master ? mc_reg : n_reg - mc_reg;
            end
            OP_NCOLS: begin
                dvd = {6'd0, n_reg};
                dvs = {3'd0, cols_reg};
            end
            OP_ICOLS: begin
                dvd = {7'd0, i_reg};
                dvs = {3'd0, cols_reg};
            end
            OP_HROWS: begin
                dvd = sh_reg;
                dvs = {3'd0, rows};
            end
            OP_WCOLS: begin
                dvd = sw_reg;
                dvs = {3'd0, cols_reg};
            end
            OP_WREM: begin
                dvd = sw_reg;
                dvs = n_minus_i;
            end
            default: begin
                dvd = sw_reg;
                dvs = 7'd1;
            end
        endcase
    end

    tlg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .quot     (quot),
        .remd     (remd),
        .busy     (div_busy),
        .done     (div_done)
    );

    // capture inputs and division results
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            i_reg    <= s_tdata[5:0];
            n_reg    <= s_tdata[12:6];
            cols_reg <= grid_cols(s_tdata[12:6]);
        end
        if (cmd.div_start) begin
            op_reg <= cmd.div_op;
        end
        if (div_done) begin
            case (op_reg)
                OP_SPLIT: sq_reg <= quot;
                OP_NCOLS: rem_reg <= remd[2:0];
                OP_ICOLS: begin
                    iq_reg <= quot[4:0];
                    ir_reg <= remd[2:0];
                end
                OP_HROWS: hq_reg <= quot;
                OP_WCOLS: wq_reg <= quot;
                OP_WREM:  wq_reg <= quot;
                default: ;
            endcase
        end
    end

    // form the rectangle before the origin is added
    always_comb begin
        mg_ext  = {{2{mg_reg[12]}}, mg_reg};
        half_w  = {3'd0, sw_reg[12:1]};
        half_h  = {3'd0, sh_reg[12:1]};
        fac     = master ? i_reg : 6'(n_reg - 7'd1 - {1'b0, i_reg});
        p_split = {6'd0, sq_reg} * {13'd0, fac};
        xn = 15'd0;
        yn = 15'd0;
        wn = 15'd0;
        hn = 15'd0;
        case (kind)
            KIND_FULL: begin
                wn = {2'd0, sw_reg};
                hn = {2'd0, sh_reg};
            end
            KIND_SPLIT: begin
                if (mode_reg == LAYOUT_VERT) begin
                    hn = {2'd0, sq_reg};
                    yn = p_split[14:0];
                    wn = master ? half_w + mg_ext : half_w - mg_ext;
                    xn = master ? 15'd0 : half_w + mg_ext;
                end else begin
                    wn = {2'd0, sq_reg};
                    xn = p_split[14:0];
                    hn = master ? half_h + mg_ext : half_h - mg_ext;
                    yn = master ? 15'd0 : half_h + mg_ext;
                end
            end
            KIND_GRID: begin
                xn = {2'd0, wq_reg} * {12'd0, ir_reg};
                yn = {2'd0, hq_reg} * {10'd0, iq_reg};
                hn = {2'd0, hq_reg};
                if ({1'b0, i_reg} >= last_row_start) begin
                    hn = {2'd0, sh_reg};
                    hn = hn - {2'd0, hq_reg} * {11'd0, rows} + {2'd0, hq_reg};
                end
                wn = {2'd0, wq_reg};
                if (rows > 4'd1 && {1'b0, i_reg} == n_reg - 7'd1 && rem_reg > 3'd1) begin
                    wn = {2'd0, sw_reg} - {2'd0, wq_reg} * {12'd0, rem_reg}
                         + {2'd0, wq_reg};
                end else if ({1'b0, ir_reg} == cols_reg - 4'd1) begin
                    wn = {2'd0, sw_reg} - {2'd0, wq_reg} * {11'd0, cols_reg}
                         + {2'd0, wq_reg};
                end
            end
            default: ;
        endcase
    end

    // hold the raw rectangle
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            xr_reg  <= xn;
            yr_reg  <= yn;
            wr_reg  <= wn;
            hr_reg  <= hn;
            bad_reg <= (kind == KIND_BAD);
        end
    end

    // output register: add the origin and present the word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            tuser_reg <= bad_reg;
            if (bad_reg) begin
                tdata_reg <= 64'd0;
            end else begin
                tdata_reg <= {4'd0, hr_reg, wr_reg,
                              yr_reg + {oy_reg[13], oy_reg},
                              xr_reg + {ox_reg[13], ox_reg}};
            end
        end
    end

    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tvalid = tvalid_reg;

    always_comb begin
        stat.kind      = kind;
        stat.need_wrem = rows > 4'd1 && {1'b0, i_reg} == last_row_start &&
                         n_minus_i <= {4'd0, rem_reg};
        stat.div_busy  = div_busy;
        stat.div_done  = div_done;
        stat.out_free  = !tvalid_reg || m_tready;
    end
endmodule

### hdl/tlg_ctrl.sv
// Controller: sequences the divisions of one tile and hands the result to the
// output register. Depends on tlg_pkg.
`timescale 1ns / 1ps

module tlg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tlg_pkg::tlg_stat_t stat,
    output tlg_pkg::tlg_cmd_t  cmd
);
    import tlg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_WAIT,
        S_MUL,
        S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    div_op_t op_reg, op_next;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_op    = op_reg;
        cmd.mul       = 1'b0;
        cmd.finish    = 1'b0;
        s_tready      = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                if (stat.kind == KIND_GRID) begin
                    op_next    = OP_NCOLS;
                    state_next = S_WAIT;
                end else if (stat.kind == KIND_SPLIT) begin
                    op_next    = OP_SPLIT;
                    state_next = S_WAIT;
                end else begin
                    state_next = S_MUL;
                end
                cmd.div_op    = op_next;
                cmd.div_start = (state_next == S_WAIT);
            end
            S_WAIT: begin
                // chain the next division as soon as one completes
                if (stat.div_done) begin
                    case (op_reg)
                        OP_NCOLS: op_next = OP_ICOLS;
                        OP_ICOLS: op_next = OP_HROWS;
                        OP_HROWS: op_next = OP_WCOLS;
                        OP_WCOLS: begin
                            if (stat.need_wrem) begin
                                op_next = OP_WREM;
                            end else begin
                                state_next = S_MUL;
                            end
                        end
                        default: state_next = S_MUL;
                    endcase
                    cmd.div_op    = op_next;
                    cmd.div_start = (state_next == S_WAIT);
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SPLIT;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> stat.out_free)
        else $error("result written while output register is occupied");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> state_reg == S_WAIT)
        else $error("division completed outside wait state");
    a_load_next: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_CLASS)
        else $error("accepted word not classified");
endmodule

### hdl/tile_layout_geometry_unit.sv
// Tile layout geometry unit: one tile rectangle per request word.
// Usage:
//   s_tdata carries tile_index [5:0] and tile_count [12:6]; one word in gives
//   exactly one word out on m_tdata (pos_x, pos_y, tile_width, tile_height,
//   15 bits each from bit 0) with bad_request on m_tuser.
//   Registers are written over cfg_valid/cfg_index/cfg_data, always ready;
//   write them only while no request is in flight.
// Sequence, input accept to output valid:
//   bad, fullscreen or single tile: load, classify, product, finish.
//   vertical/horizontal: one division, then product and finish.
//   grid: four or five chained divisions, then product and finish.
//   All divisions run on the shared bit-serial divider; one item is in work at
//   a time, so the next word is accepted in the cycle after a result is written.
// A finished word waits in the output register while the receiver stalls;
// the next request is accepted meanwhile and held before the output stage.
// Reset (aresetn low, synchronous) loads the register defaults and empties
// the output register.
// Depends on tlg_pkg, tlg_ctrl, tlg_dp and tlg_div.
`timescale 1ns / 1ps

module tile_layout_geometry_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // tile_index [5:0], tile_count [12:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pos_x, pos_y, tile_width, tile_height
    output logic        m_tuser,   // bad_request
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);
    import tlg_pkg::*;

    tlg_cmd_t  cmd;
    tlg_stat_t stat;

    assign cfg_ready = 1'b1;

    tlg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlg_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );
endmodule

### test/testbench.sv
// Self-checking bench for the tile layout geometry unit: a queue-fed
// request driver, a result monitor checking against a built-in predictor.
// Depends on tlg_pkg and tile_layout_geometry_unit.
`timescale 1ns / 1ps

module testbench;
    import tlg_pkg::*;

    // index in the low bits, as on s_tdata
    typedef struct packed {
        logic [6:0] tile_count;
        logic [5:0] tile_index;
    } tile_req_t;

    typedef struct packed {
        logic [14:0] pos_x;
        logic [14:0] pos_y;
        logic [14:0] tile_width;
        logic [14:0] tile_height;
        logic        bad_request;
    } tile_rect_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [13:0] cfg_data = '0;

    tile_layout_geometry_unit uut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor copy of the registers
    int unsigned scr_w, scr_h, mode_q, mast_q;
    int          org_x, org_y, margin_q;

    tile_req_t  req_q[$];
    tile_rect_t rect_q[$];
    int         errors = 0;
    bit         hold_send = 0;
    bit         long_stall = 0;
    int         idle_cycles = 0;

    function automatic tile_rect_t layout_rect(tile_req_t r);
        tile_rect_t o;
        int i, n, x, y, w, h, cols, rows, rem, ah, aw, m, mg;
        i = r.tile_index; n = r.tile_count; m = mast_q; mg = margin_q;
        x = 0; y = 0; w = 0; h = 0;
        o = '0;
        if (n == 0 || i >= n || n > MAX_TILES) begin
            o.bad_request = 1;
            return o;
        end
        if (n == 1 || mode_q == LAYOUT_FULL) begin
            w = scr_w; h = scr_h;
        end else if (mode_q == LAYOUT_VERT) begin
            if (i < m) begin
                h = scr_h / m; y = h * i; w = scr_w / 2 + mg;
            end else begin
                h = scr_h / (n - m); y = h * (n - 1 - i);
                x = scr_w / 2 + mg; w = scr_w / 2 - mg;
            end
        end else if (mode_q == LAYOUT_HORIZ) begin
            if (i < m) begin
                w = scr_w / m; x = w * i; h = scr_h / 2 + mg;
            end else begin
                w = scr_w / (n - m); x = w * (n - 1 - i);
                y = scr_h / 2 + mg; h = scr_h / 2 - mg;
            end
        end else begin
            cols = 1;
            while (cols * cols < n) cols++;
            rows = ((cols - 1) * cols >= n) ? cols - 1 : cols;
            rem = n % cols;
            h = scr_h / rows;
            w = scr_w / cols;
            if (rows > 1 && i == rows * cols - cols && (n - i) <= rem) w = scr_w / (n - i);
            x = (i % cols) * w;
            y = (i / cols) * h;
            ah = (i >= cols * (rows - 1)) ? scr_h - h * rows : 0;
            if (rows > 1 && i == n - 1 && (n - i) < rem) aw = scr_w - w * rem;
            else aw = ((i + 1) % cols == 0) ? scr_w - w * cols : 0;
            w += aw; h += ah;
        end
        o.pos_x = 15'(x + org_x);
        o.pos_y = 15'(y + org_y);
        o.tile_width = 15'(w);
        o.tile_height = 15'(h);
        return o;
    endfunction

    // request driver: bursts with random gaps
    int gap_left = 0, burst_left = 0;
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            rect_q.push_back(layout_rect(tile_req_t'(s_tdata[12:0])));
            void'(req_q.pop_front());
        end
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (s_tvalid && !s_tready) begin
            s_tvalid <= 1;
        end else if (hold_send) begin
            s_tvalid <= 0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 0;
        end else begin
            // the popped head is gone; offer the next pending one
            if ((s_tvalid && s_tready ? req_q.size() > 0 : req_q.size() > 0)) begin
                s_tvalid <= 1;
                s_tdata <= {3'b0, req_q[0]};
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 60);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // result monitor and receiver stall pattern
    int stall_cnt = 0;
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            tile_rect_t got, exp_r;
            got.pos_x = m_tdata[14:0];
            got.pos_y = m_tdata[29:15];
            got.tile_width = m_tdata[44:30];
            got.tile_height = m_tdata[59:45];
            got.bad_request = m_tuser;
            if (rect_q.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
            end else begin
                exp_r = rect_q.pop_front();
                if (got.pos_x !== exp_r.pos_x) begin
                    $error("pos_x exp %0h got %0h", exp_r.pos_x, got.pos_x); errors++;
                end
                if (got.pos_y !== exp_r.pos_y) begin
                    $error("pos_y exp %0h got %0h", exp_r.pos_y, got.pos_y); errors++;
                end
                if (got.tile_width !== exp_r.tile_width) begin
                    $error("tile_width exp %0h got %0h", exp_r.tile_width,
                        got.tile_width); errors++;
                end
                if (got.tile_height !== exp_r.tile_height) begin
                    $error("tile_height exp %0h got %0h", exp_r.tile_height,
                        got.tile_height); errors++;
                end
                if (got.bad_request !== exp_r.bad_request) begin
                    $error("bad_request exp %0b got %0b", exp_r.bad_request,
                        got.bad_request); errors++;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 0;
        end else if (long_stall) begin
            m_tready <= 0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
            if ($urandom_range(0, 15) == 0) stall_cnt <= $urandom_range(1, 90);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tile_layout_geometry_unit regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (req_q.size() != 0 || rect_q.size() != 0 || s_tvalid) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [13:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
        case (idx)
            REG_SCREEN_WIDTH:  scr_w = val[12:0];
            REG_SCREEN_HEIGHT: scr_h = val[12:0];
            REG_ORIGIN_X:      org_x = $signed(val[13:0]);
            REG_ORIGIN_Y:      org_y = $signed(val[13:0]);
            REG_SPLIT_MARGIN:  margin_q = $signed(val[12:0]);
            REG_LAYOUT_MODE:   mode_q = val[1:0];
            REG_MASTER_COUNT:  mast_q = val[6:0];
            default: ;
        endcase
    endtask

    task automatic push_req(int idx, int cnt);
        tile_req_t r;
        r.tile_index = 6'(idx);
        r.tile_count = 7'(cnt);
        req_q.push_back(r);
    endtask

    task automatic random_regs(bit extreme);
        write_reg(REG_SCREEN_WIDTH, extreme ? ($urandom_range(0, 1) ? 14'd8191 : 14'd1)
                                            : 14'($urandom_range(1, 8191)));
        write_reg(REG_SCREEN_HEIGHT, extreme ? ($urandom_range(0, 1) ? 14'd8191 : 14'd1)
                                             : 14'($urandom_range(1, 8191)));
        write_reg(REG_ORIGIN_X, extreme ? ($urandom_range(0, 1) ? 14'h1FFF : 14'h2000)
                                        : 14'($urandom));
        write_reg(REG_ORIGIN_Y, extreme ? ($urandom_range(0, 1) ? 14'h1FFF : 14'h2000)
                                        : 14'($urandom));
        write_reg(REG_SPLIT_MARGIN, extreme ? ($urandom_range(0, 1) ? 14'h0FFF : 14'h1000)
                                            : 14'($urandom_range(0, 8191)));
        write_reg(REG_MASTER_COUNT, extreme ? ($urandom_range(0, 1) ? 14'd64 : 14'd0)
                                            : 14'($urandom_range(0, 12)));
    endtask

    initial begin
        int ph, k, n;
        scr_w = 1920; scr_h = 1080; org_x = 0; org_y = 0;
        margin_q = 120; mode_q = 0; mast_q = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset defaults, bad requests, single tile, each mode
        push_req(0, 1); push_req(0, 0); push_req(63, 64); push_req(5, 5);
        push_req(63, 127); push_req(0, 65); push_req(0, 2); push_req(1, 2);
        push_req(2, 3);
        wait_drained();
        for (int md = 0; md < 4; md++) begin
            write_reg(REG_LAYOUT_MODE, 14'(md));
            push_req(0, 5); push_req(4, 5); push_req(63, 64); push_req(56, 64);
            push_req(6, 7); push_req(2, 3);
            wait_drained();
        end
        write_reg(REG_MASTER_COUNT, 14'd0);
        write_reg(REG_LAYOUT_MODE, 14'(LAYOUT_VERT));
        push_req(0, 3); push_req(2, 3);
        wait_drained();
        write_reg(REG_MASTER_COUNT, 14'd64);
        push_req(0, 3); push_req(1, 3);
        wait_drained();

        // random phases of settings, mostly valid requests with small counts
        for (ph = 0; ph < 20; ph++) begin
            random_regs(ph % 4 == 0);
            write_reg(REG_LAYOUT_MODE, 14'($urandom_range(0, 3)));
            if (ph == 3) begin
                fork
                    begin
                        long_stall = 1;
                        repeat (800) @(posedge aclk);
                        long_stall = 0;
                    end
                join_none
            end
            for (k = 0; k < 50; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_req($urandom_range(0, 63), $urandom_range(0, 127));
                end else begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                                    : $urandom_range(1, 16);
                    push_req($urandom_range(0, n - 1), n);
                end
            end
            if (ph == 10) begin
                while (req_q.size() > 25) @(posedge aclk);
                hold_send = 1;
                while (rect_q.size() != 0) @(posedge aclk);
                hold_send = 0;
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("tile_layout_geometry_unit regression: pass");
        end else begin
            $display("tile_layout_geometry_unit regression: fail");
        end
        $finish;
    end

endmodule

### tile_layout_geometry_unit.f
hdl/tlg_pkg.sv
hdl/tlg_div.sv
hdl/tlg_dp.sv
hdl/tlg_ctrl.sv
hdl/tile_layout_geometry_unit.sv
test/testbench.sv
